[rtl/kcms_pkg.sv]
// kcms_pkg: shared types and constants of the k-mer count / motif select unit.
// Used by kcms_ctrl, kcms_dp and kmer_count_motif_select_unit. No dependencies.
package kcms_pkg;

  localparam int KLEN_W = 4;
  localparam int CHAR_W = 8;
  localparam logic [KLEN_W-1:0] KMER_LEN_RESET = 4'd7;

  // input beat kind, carried on s_tuser
  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_SEQ    = 2'd1,
    OP_SELECT = 2'd2,
    OP_CLEAR  = 2'd3
  } kcms_op_t;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_UPDATE = 6'b000100,
    S_SCAN   = 6'b001000,
    S_TAIL   = 6'b010000,
    S_RESULT = 6'b100000
  } kcms_state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input beat accepted this cycle
    logic upd_wr;    // write back updated table entry
    logic sweep_wr;  // zero entry at sweep counter
    logic scan_rd;   // read entry at sweep counter for select
    logic res_load;  // load output register
  } kcms_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;        // offered character completes a k-mer
    logic sweep_last; // counter at last table entry
    logic scan_last;  // counter at last code for current k
    logic out_free;   // output register can take a result
  } kcms_sts_t;

  // ASCII to base code, lower case folded; bit 2 marks a valid base
  function automatic logic [2:0] base_of(input logic [CHAR_W-1:0] ch);
    logic [2:0] r;
    case (ch)
      8'h41, 8'h61: r = 3'b100;  // A a
      8'h43, 8'h63: r = 3'b101;  // C c
      8'h47, 8'h67: r = 3'b110;  // G g
      8'h54, 8'h74: r = 3'b111;  // T t
      default:      r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

[rtl/kcms_ram.sv]
// kcms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module kcms_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 262144,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/kcms_ctrl.sv]
// kcms_ctrl: sequencer of the k-mer count / motif select unit.
// Depends on kcms_pkg; drives kcms_dp through kcms_cmd_t.
module kcms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  kcms_pkg::kcms_op_t  in_op,
  output logic                in_ready,
  input  kcms_pkg::kcms_sts_t sts,
  output kcms_pkg::kcms_cmd_t cmd
);
  import kcms_pkg::*;

  kcms_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.take     = (state == S_IDLE) && in_valid;
    case (state)
      S_CLEAR: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_CHAR:   state_next = sts.hit ? S_UPDATE : S_IDLE;
            OP_SEQ:    state_next = S_IDLE;
            OP_SELECT: state_next = S_SCAN;
            OP_CLEAR:  state_next = S_CLEAR;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_UPDATE: begin
        cmd.upd_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_next = S_TAIL;
      end
      S_TAIL: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[rtl/kcms_dp.sv]
// kcms_dp: window, counters table, select scan and output register.
// Depends on kcms_pkg and kcms_ram; commanded by kcms_ctrl.
module kcms_dp #(
  parameter int MAX_K = 9,
  parameter int COUNT_BITS = 16,
  localparam int ADDR_W = 2 * MAX_K
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kcms_pkg::kcms_cmd_t         cmd,
  output kcms_pkg::kcms_sts_t         sts,
  input  kcms_pkg::kcms_op_t          in_op,
  input  logic [kcms_pkg::CHAR_W-1:0] in_char,
  input  logic                        cfg_we,
  input  logic [kcms_pkg::KLEN_W-1:0] cfg_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [ADDR_W-1:0]           out_code,
  output logic [COUNT_BITS-1:0]       out_total,
  output logic [COUNT_BITS-1:0]       out_cover,
  output logic                        out_ovf
);
  import kcms_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;
  localparam int ENT_W = 3 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [KLEN_W-1:0] K_MAX = KLEN_W'(MAX_K);

  logic [KLEN_W-1:0]     kmer_len;
  logic [ADDR_W-1:0]     window;
  logic [KLEN_W-1:0]     fill;
  logic [COUNT_BITS-1:0] seq_id;
  logic                  sat;
  logic [ADDR_W-1:0]     sc;
  logic [ADDR_W-1:0]     idx;
  logic                  eval_vld;
  logic [ADDR_W-1:0]     eval_addr;
  logic                  best_found;
  logic [ADDR_W-1:0]     best_code;
  logic [COUNT_BITS-1:0] best_total;
  logic [COUNT_BITS-1:0] best_cover;

  logic [KLEN_W-1:0]     k_eff;
  logic [ADDR_W-1:0]     k_mask;
  logic [2:0]            base;
  logic [ADDR_W-1:0]     window_next;
  logic [KLEN_W-1:0]     fill_next;
  logic [ADDR_W-1:0]     idx_next;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;

  logic [COUNT_BITS-1:0] r_total, r_cover, r_last;
  logic [COUNT_BITS-1:0] u_total, u_cover, u_last;
  logic                  u_sat;
  logic [COUNT_BITS+1:0] twice_t, thrice_c;
  logic                  e_pass, e_better;

  // effective k and code mask
  always_comb begin
    if (kmer_len == '0) k_eff = KLEN_W'(1);
    else if (kmer_len > K_MAX) k_eff = K_MAX;
    else k_eff = kmer_len;
    k_mask = ~({ADDR_W{1'b1}} << {k_eff, 1'b0});
  end

  // window shift for the offered character
  always_comb begin
    base        = base_of(in_char);
    window_next = ADDR_W'({window, base[1:0]});
    fill_next   = (fill < K_MAX) ? fill + 1'b1 : fill;
    idx_next    = window_next & k_mask;
  end

  assign sts.hit        = (in_op == OP_CHAR) && base[2] && (fill_next >= k_eff);
  assign sts.sweep_last = (sc == '1);
  assign sts.scan_last  = (sc == k_mask);
  assign sts.out_free   = !out_valid || out_ready;

  // table entry: {last_seen, coverage, total}
  assign r_total = ram_rdata[COUNT_BITS-1:0];
  assign r_cover = ram_rdata[2*COUNT_BITS-1:COUNT_BITS];
  assign r_last  = ram_rdata[3*COUNT_BITS-1:2*COUNT_BITS];

  always_comb begin
    u_sat   = 1'b0;
    u_total = r_total;
    u_cover = r_cover;
    u_last  = r_last;
    if (r_total == CNT_MAX) u_sat = 1'b1;
    else u_total = r_total + 1'b1;
    if (r_last != seq_id) begin
      u_last = seq_id;
      if (r_cover == CNT_MAX) u_sat = 1'b1;
      else u_cover = r_cover + 1'b1;
    end
  end

  // 2*total <= 3*coverage, exact
  always_comb begin
    twice_t  = {1'b0, r_total, 1'b0};
    thrice_c = {2'b00, r_cover} + {1'b0, r_cover, 1'b0};
    e_pass   = (r_total != '0) && (r_cover != '0) && (twice_t <= thrice_c);
    e_better = !best_found || (r_cover > best_cover) ||
               ((r_cover == best_cover) && (r_total < best_total));
  end

  always_comb begin
    ram_we    = cmd.upd_wr || cmd.sweep_wr;
    ram_waddr = cmd.sweep_wr ? sc : idx;
    ram_wdata = cmd.sweep_wr ? '0 : {u_last, u_cover, u_total};
    ram_raddr = cmd.scan_rd ? sc : idx_next;
  end

  kcms_ram #(
    .WIDTH(ENT_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= KMER_LEN_RESET;
    end else if (cfg_we) begin
      kmer_len <= cfg_data;
    end
  end

  // sequence state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      fill     <= '0;
      seq_id   <= COUNT_BITS'(1);
      sat      <= 1'b0;
      sc       <= '0;
      eval_vld <= 1'b0;
    end else begin
      eval_vld <= cmd.scan_rd;
      if (cmd.sweep_wr || cmd.scan_rd) begin
        sc <= sc + 1'b1;
      end
      if (cmd.upd_wr && u_sat) begin
        sat <= 1'b1;
      end
      if (cmd.take) begin
        sc <= '0;
        case (in_op)
          OP_CHAR: begin
            if (base[2]) begin
              window <= window_next;
              fill   <= fill_next;
            end
          end
          OP_SEQ: begin
            window <= '0;
            fill   <= '0;
            if (seq_id == CNT_MAX) sat <= 1'b1;
            else seq_id <= seq_id + 1'b1;
          end
          OP_CLEAR: begin
            window <= '0;
            fill   <= '0;
            seq_id <= COUNT_BITS'(1);
            sat    <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx       <= cmd.take ? idx_next : idx;
    eval_addr <= sc;
  end

  // running best over the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      best_code  <= '0;
      best_total <= '0;
      best_cover <= '0;
    end else if (cmd.take && (in_op == OP_SELECT)) begin
      best_found <= 1'b0;
      best_code  <= '0;
      best_total <= '0;
      best_cover <= '0;
    end else if (eval_vld && e_pass && e_better) begin
      best_found <= 1'b1;
      best_code  <= eval_addr;
      best_total <= r_total;
      best_cover <= r_cover;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_found <= best_found;
      out_code  <= best_code;
      out_total <= best_total;
      out_cover <= best_cover;
      out_ovf   <= sat;
    end
  end

endmodule

[rtl/kmer_count_motif_select_unit.sv]
// kmer_count_motif_select_unit: top level of the k-mer count / motif select unit.
// Depends on kcms_pkg, kcms_ctrl, kcms_dp (which holds kcms_ram).
//
// Counts k-mers of a DNA character stream and picks a motif candidate. Each
// s_tuser beat kind: character, start of new sequence, select, clear. Case
// is folded and non-ACGT characters are skipped without breaking the window.
// A counted k-mer takes an accept beat plus a table write-back; a
// skipped character or a new-sequence beat takes only the accept beat.
// Select reads every code below 4^k from the table, one per cycle, and
// then offers the result beat on m_*. Clear and reset zero the whole
// table, one entry per cycle, 4^MAX_K entries (262144 with MAX_K = 9),
// during which s_tready stays low. These costs come from the single
// table RAM with one read and one write port. kmer_len (cfg_data) is taken
// at any time but should only change while the unit is idle.
module kmer_count_motif_select_unit #(
  parameter int MAX_K = 9,
  parameter int COUNT_BITS = 16,
  localparam int OUT_W = 2 + 2 * MAX_K + 2 * COUNT_BITS,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // input item stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kcms_pkg::CHAR_W-1:0]   s_tdata,  // [7:0] char_in
  input  logic [1:0]                    s_tuser,  // [1:0] cmd
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // from bit 0: found, kmer_code, total_count, coverage_count, overflow, zero fill
  output logic [OUT_TDATA_W-1:0]        m_tdata,
  // kmer_len register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kcms_pkg::KLEN_W-1:0]   cfg_data
);
  import kcms_pkg::*;

  kcms_cmd_t             cmd;
  kcms_sts_t             sts;
  kcms_op_t              op;
  logic                  out_found;
  logic [2*MAX_K-1:0]    out_code;
  logic [COUNT_BITS-1:0] out_total;
  logic [COUNT_BITS-1:0] out_cover;
  logic                  out_ovf;

  assign op        = kcms_op_t'(s_tuser);
  assign cfg_ready = 1'b1;

  kcms_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_op   (op),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  kcms_dp #(
    .MAX_K     (MAX_K),
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .in_op    (op),
    .in_char  (s_tdata),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_found(out_found),
    .out_code (out_code),
    .out_total(out_total),
    .out_cover(out_cover),
    .out_ovf  (out_ovf)
  );

  // zero-extended to whole bytes
  assign m_tdata = OUT_TDATA_W'({out_ovf, out_cover, out_total, out_code, out_found});

endmodule
